>>> design/mfcr_pkg.sv
// Shared constants, codes and types of the marker framed command receiver.
package mfcr_pkg;

    localparam int BUFFER_DEPTH = 35;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(BUFFER_DEPTH);

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAD_RUN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = 3'd3;

    localparam logic [7:0]       RST_END_MARKER    = 8'h73;
    localparam logic [7:0]       RST_PAD_BYTE      = 8'hFF;
    localparam logic [1:0]       RST_MIN_PAD_RUN   = 2'd2;
    localparam logic [IDX_W-1:0] RST_MIN_FRAME_LEN = 6'd7;

    typedef struct packed {
        logic exec;
        logic rd_start;
        logic rd_step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic frame_pending;
        logic rd_last;
    } t_dp_status;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic             frame_ready;
        logic [IDX_W-1:0] frame_length;
        logic             last;
        logic             overflowed;
        logic             dropped;
    } t_result;

endpackage

>>> design/mfcr_in_if.sv
// Input channel interface carrying commands and received bytes.
interface mfcr_in_if;
    logic                      valid;
    logic                      ready;
    logic [mfcr_pkg::CMD_W-1:0] command;
    logic [7:0]                rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

>>> design/mfcr_out_if.sv
// Output channel interface carrying status results and frame data bytes.
interface mfcr_out_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [7:0]                data_byte;
    logic                      frame_ready;
    logic [mfcr_pkg::IDX_W-1:0] frame_length;
    logic                      last;
    logic                      overflowed;
    logic                      dropped;

    modport source (output valid, output kind, output data_byte, output frame_ready,
                    output frame_length, output last, output overflowed,
                    output dropped, input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_ready,
                    input frame_length, input last, input overflowed,
                    input dropped, output ready);
endinterface

>>> design/mfcr_ctrl.sv
// Controller state machine sequencing command execution and frame read out.
module mfcr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [mfcr_pkg::CMD_W-1:0] i_command,
    input  mfcr_pkg::t_dp_status       i_status,
    output logic                       o_ready,
    output mfcr_pkg::t_dp_cmd          o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_status.out_free;
                if (i_valid && i_status.out_free) begin
                    if (i_command == mfcr_pkg::CMD_READ && i_status.frame_pending) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = ST_READ;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (i_status.out_free) begin
                    o_cmd.rd_step = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/mfcr_datapath.sv
// Datapath with configuration registers, frame store, fill tracking and output register.
module mfcr_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [mfcr_pkg::CMD_W-1:0]      i_command,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_cfg_we,
    input  logic [mfcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mfcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  mfcr_pkg::t_dp_cmd               i_cmd,
    input  logic                            i_out_ready,
    output mfcr_pkg::t_dp_status            o_status,
    output logic                            o_out_valid,
    output mfcr_pkg::t_result               o_result
);

    logic [7:0]                 r_end_marker;
    logic [7:0]                 r_pad_byte;
    logic [1:0]                 r_min_pad;
    logic [mfcr_pkg::IDX_W-1:0] r_min_len;

    logic [7:0]                 r_mem [mfcr_pkg::BUFFER_DEPTH];
    logic [7:0]                 r_rd_data;
    logic [mfcr_pkg::IDX_W-1:0] r_rd_idx;

    logic [mfcr_pkg::IDX_W-1:0] r_fill, n_fill;
    logic [1:0]                 r_pad, n_pad;
    logic [mfcr_pkg::IDX_W-1:0] r_latched, n_latched;

    logic                       r_out_valid;
    mfcr_pkg::t_result          r_out;

    logic [mfcr_pkg::IDX_W-1:0] fill_inc;
    logic [mfcr_pkg::IDX_W-1:0] rd_addr;
    logic                       hit;
    logic                       wr_en;
    logic                       ovf;
    logic                       drop;
    logic                       rd_last;

    assign fill_inc = r_fill + 1'b1;
    assign hit      = (i_rx_byte == r_end_marker) && (r_pad >= r_min_pad) &&
                      (fill_inc >= r_min_len);
    assign rd_last  = (r_rd_idx + 1'b1) == r_latched;

    always_comb begin
        n_fill    = r_fill;
        n_pad     = r_pad;
        n_latched = r_latched;
        wr_en     = 1'b0;
        ovf       = 1'b0;
        drop      = 1'b0;
        if (i_cmd.exec) begin
            unique case (i_command)
                mfcr_pkg::CMD_RECEIVE: begin
                    if (r_latched != '0) begin
                        drop = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                        priority if (hit) begin
                            n_latched = fill_inc;
                            n_fill    = '0;
                            n_pad     = '0;
                        end else if (fill_inc >= mfcr_pkg::DEPTH_IDX) begin
                            n_fill = '0;
                            n_pad  = '0;
                            ovf    = 1'b1;
                        end else if (i_rx_byte == r_pad_byte) begin
                            n_fill = fill_inc;
                            if (r_pad != 2'd3) begin
                                n_pad = r_pad + 2'd1;
                            end
                        end else begin
                            n_fill = fill_inc;
                            n_pad  = '0;
                        end
                    end
                end
                mfcr_pkg::CMD_RELEASE: n_latched = '0;
                default: ;
            endcase
        end
    end

    // The read address runs one entry ahead of the output so bytes stream each cycle unless the output stalls.
    always_comb begin
        priority if (i_cmd.rd_start) begin
            rd_addr = '0;
        end else if (i_cmd.rd_step && !rd_last) begin
            rd_addr = r_rd_idx + 1'b1;
        end else begin
            rd_addr = r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill] <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_step) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.kind         <= 1'b0;
            r_out.data_byte    <= '0;
            r_out.frame_ready  <= n_latched != '0;
            r_out.frame_length <= n_latched;
            r_out.last         <= 1'b1;
            r_out.overflowed   <= ovf;
            r_out.dropped      <= drop;
        end else if (i_cmd.rd_step) begin
            r_out.kind         <= 1'b1;
            r_out.data_byte    <= r_rd_data;
            r_out.frame_ready  <= 1'b1;
            r_out.frame_length <= r_latched;
            r_out.last         <= rd_last;
            r_out.overflowed   <= 1'b0;
            r_out.dropped      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_pad        <= '0;
            r_latched    <= '0;
            r_out_valid  <= 1'b0;
            r_end_marker <= mfcr_pkg::RST_END_MARKER;
            r_pad_byte   <= mfcr_pkg::RST_PAD_BYTE;
            r_min_pad    <= mfcr_pkg::RST_MIN_PAD_RUN;
            r_min_len    <= mfcr_pkg::RST_MIN_FRAME_LEN;
        end else begin
            r_fill    <= n_fill;
            r_pad     <= n_pad;
            r_latched <= n_latched;
            if (i_cmd.exec || i_cmd.rd_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mfcr_pkg::CFG_END_MARKER:    r_end_marker <= i_cfg_data;
                    mfcr_pkg::CFG_PAD_BYTE:      r_pad_byte   <= i_cfg_data;
                    mfcr_pkg::CFG_MIN_PAD_RUN:   r_min_pad    <= i_cfg_data[1:0];
                    mfcr_pkg::CFG_MIN_FRAME_LEN: r_min_len    <= i_cfg_data[mfcr_pkg::IDX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_status.out_free      = !r_out_valid || i_out_ready;
    assign o_status.frame_pending = r_latched != '0;
    assign o_status.rd_last       = rd_last;
    assign o_out_valid            = r_out_valid;
    assign o_result               = r_out;

endmodule

>>> design/marker_framed_command_receiver.sv
// Top level of the marker framed command receiver.
//
//   channel   direction  transfer carries
//   i_in      in         command, rx_byte
//   o_out     out        kind, data_byte, frame_ready, frame_length, last,
//                        overflowed, dropped
//   i_cfg_*   in         register index and write data, no handshake
//
// Receive, release and status commands each give one result.
// A read of a latched frame first primes the registered frame store read port,
// then gives one result per stored byte, and no command is taken meanwhile.
// A stalled output holds its result and blocks further transfers at the input.
// Reset clears the fill index, pad run, latched length and output valid and
// loads the configuration defaults; the frame store is not cleared.
module marker_framed_command_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mfcr_in_if.sink                         i_in,
    mfcr_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [mfcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mfcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mfcr_pkg::t_dp_cmd    dp_cmd;
    mfcr_pkg::t_dp_status dp_status;
    mfcr_pkg::t_result    result;
    logic                 in_ready;
    logic                 out_valid;

    mfcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .i_status  (dp_status),
        .o_ready   (in_ready),
        .o_cmd     (dp_cmd)
    );

    mfcr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_command   (i_in.command),
        .i_rx_byte   (i_in.rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .i_out_ready (o_out.ready),
        .o_status    (dp_status),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.kind         = result.kind;
    assign o_out.data_byte    = result.data_byte;
    assign o_out.frame_ready  = result.frame_ready;
    assign o_out.frame_length = result.frame_length;
    assign o_out.last         = result.last;
    assign o_out.overflowed   = result.overflowed;
    assign o_out.dropped      = result.dropped;

`ifndef SYNTHESIS
    a_ready_flag_matches_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.frame_ready == (o_out.frame_length != '0)))
        else $error("frame_ready disagrees with frame_length");

    a_data_only_with_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind) |-> (o_out.frame_ready && !o_out.overflowed &&
                                         !o_out.dropped))
        else $error("data result without a latched frame or with status flags");

    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.command == mfcr_pkg::CMD_READ &&
         dp_status.frame_pending) |=> !i_in.ready)
        else $error("input taken while a frame read out is running");

    a_single_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.exec, dp_cmd.rd_start, dp_cmd.rd_step}))
        else $error("controller issued more than one datapath action");
`endif

endmodule

>>> bench/tb_marker_framed_command_receiver.sv
// Testbench of the marker framed command receiver: random command streams checked by a scoreboard.
module tb_marker_framed_command_receiver;

    localparam logic [mfcr_pkg::CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam logic                       KIND_STATUS = 1'b0;
    localparam logic                       KIND_DATA   = 1'b1;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 1000;

    class frame_scoreboard;
        logic [7:0]                 frame_bytes [mfcr_pkg::BUFFER_DEPTH];
        logic [mfcr_pkg::IDX_W-1:0] fill_idx;
        logic [1:0]                 pad_run;
        logic [mfcr_pkg::IDX_W-1:0] held_len;
        logic [7:0]                 marker;
        logic [7:0]                 pad;
        logic [1:0]                 min_run;
        logic [mfcr_pkg::IDX_W-1:0] min_len;
        mfcr_pkg::t_result          results_due [$];
        int                         errors;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            fill_idx = '0;
            pad_run  = '0;
            held_len = '0;
            marker   = mfcr_pkg::RST_END_MARKER;
            pad      = mfcr_pkg::RST_PAD_BYTE;
            min_run  = mfcr_pkg::RST_MIN_PAD_RUN;
            min_len  = mfcr_pkg::RST_MIN_FRAME_LEN;
            errors   = 0;
        endfunction

        function void write_reg(logic [mfcr_pkg::CFG_IDX_W-1:0] idx,
                                logic [mfcr_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                mfcr_pkg::CFG_END_MARKER:    marker  = val;
                mfcr_pkg::CFG_PAD_BYTE:      pad     = val;
                mfcr_pkg::CFG_MIN_PAD_RUN:   min_run = val[1:0];
                mfcr_pkg::CFG_MIN_FRAME_LEN: min_len = val[mfcr_pkg::IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function void apply_command(logic [mfcr_pkg::CMD_W-1:0] cmd, logic [7:0] rx);
            mfcr_pkg::t_result r;
            int                n;
            r = '0;
            r.kind = KIND_STATUS;
            r.last = 1'b1;
            case (cmd)
                mfcr_pkg::CMD_RECEIVE: begin
                    if (held_len != 0) begin
                        r.dropped = 1'b1;
                    end else begin
                        if (fill_idx < mfcr_pkg::BUFFER_DEPTH) frame_bytes[fill_idx] = rx;
                        fill_idx = fill_idx + 1'b1;
                        if (rx == marker && pad_run >= min_run && fill_idx >= min_len) begin
                            held_len = fill_idx;
                            fill_idx = '0;
                            pad_run  = '0;
                        end else if (fill_idx >= mfcr_pkg::BUFFER_DEPTH) begin
                            fill_idx     = '0;
                            pad_run      = '0;
                            r.overflowed = 1'b1;
                        end else if (rx == pad) begin
                            if (pad_run != 2'd3) pad_run = pad_run + 1'b1;
                        end else begin
                            pad_run = '0;
                        end
                    end
                end
                mfcr_pkg::CMD_READ: begin
                    if (held_len != 0) begin
                        n = held_len;
                        for (int i = 0; i < n; i++) begin
                            r.kind         = KIND_DATA;
                            r.data_byte    = frame_bytes[i];
                            r.frame_ready  = 1'b1;
                            r.frame_length = held_len;
                            r.last         = (i == n - 1);
                            results_due.push_back(r);
                        end
                        return;
                    end
                end
                mfcr_pkg::CMD_RELEASE: held_len = '0;
                default: ;
            endcase
            r.frame_ready  = (held_len != 0);
            r.frame_length = held_len;
            results_due.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(mfcr_pkg::t_result got);
            mfcr_pkg::t_result want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual %0h", $time, got);
                return;
            end
            want = results_due.pop_front();
            compare("kind", want.kind, got.kind);
            compare("data_byte", want.data_byte, got.data_byte);
            compare("frame_ready", want.frame_ready, got.frame_ready);
            compare("frame_length", want.frame_length, got.frame_length);
            compare("last", want.last, got.last);
            compare("overflowed", want.overflowed, got.overflowed);
            compare("dropped", want.dropped, got.dropped);
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [mfcr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mfcr_pkg::CFG_DATA_W-1:0] cfg_data;

    mfcr_in_if  in_ch ();
    mfcr_out_if out_ch ();

    frame_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int hold_requests;
    int hold_served  = 0;
    int hold_left    = 0;
    int stall_cycles = 0;

    marker_framed_command_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        mfcr_pkg::t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind         = out_ch.kind;
            got.data_byte    = out_ch.data_byte;
            got.frame_ready  = out_ch.frame_ready;
            got.frame_length = out_ch.frame_length;
            got.last         = out_ch.last;
            got.overflowed   = out_ch.overflowed;
            got.dropped      = out_ch.dropped;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [mfcr_pkg::CMD_W-1:0] cmd, input logic [7:0] rx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.rx_byte <= rx;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.apply_command(cmd, rx);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mfcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfcr_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] m, input logic [7:0] p,
                              input logic [1:0] run, input logic [5:0] len);
        write_reg(mfcr_pkg::CFG_END_MARKER, m);
        write_reg(mfcr_pkg::CFG_PAD_BYTE, p);
        write_reg(mfcr_pkg::CFG_MIN_PAD_RUN, mfcr_pkg::CFG_DATA_W'(run));
        write_reg(mfcr_pkg::CFG_MIN_FRAME_LEN, mfcr_pkg::CFG_DATA_W'(len));
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.results_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [7:0] frame_byte();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 2) return sb.pad;
        if (pick == 2) return sb.marker;
        return 8'($urandom);
    endfunction

    task automatic send_frame(input bit long_body);
        int pads;
        int body;
        int need;
        pads = sb.min_run + $urandom_range(0, 3 - sb.min_run);
        need = int'(sb.min_len) - pads - 1;
        if (need < 0) need = 0;
        body = long_body ? $urandom_range(0, 34 - pads) : need + $urandom_range(0, 3);
        if (body > 34 - pads) body = 34 - pads;
        repeat (body) send_item(mfcr_pkg::CMD_RECEIVE, frame_byte());
        repeat (pads) send_item(mfcr_pkg::CMD_RECEIVE, sb.pad);
        send_item(mfcr_pkg::CMD_RECEIVE, sb.marker);
    endtask

    task automatic random_segment(input int n);
        int goal;
        goal = items_sent + n;
        while (items_sent < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_frame($urandom_range(0, 7) == 0);
                    repeat ($urandom_range(0, 2))
                        send_item(mfcr_pkg::CMD_RECEIVE, 8'($urandom));
                    if ($urandom_range(0, 4) != 0)
                        send_item(mfcr_pkg::CMD_READ, 8'($urandom));
                    send_item(mfcr_pkg::CMD_RELEASE, 8'($urandom));
                end
                6, 7: repeat ($urandom_range(1, 4))
                    send_item(mfcr_pkg::CMD_RECEIVE, frame_byte());
                8: send_item($urandom_range(0, 1) ? mfcr_pkg::CMD_READ : mfcr_pkg::CMD_RELEASE,
                             8'($urandom));
                default: send_item(CMD_UNUSED, 8'($urandom));
            endcase
        end
    endtask

    initial begin
        logic [7:0] short_frame [$];
        in_ch.valid   = 1'b0;
        in_ch.command = mfcr_pkg::CMD_RECEIVE;
        in_ch.rx_byte = 8'h00;
        cfg_we        = 1'b0;
        cfg_index     = mfcr_pkg::CFG_END_MARKER;
        cfg_data      = '0;
        i_rst_n       = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 65;
        items_sent    = 0;
        hold_requests = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(mfcr_pkg::CMD_READ, 8'h00);
        send_item(mfcr_pkg::CMD_RELEASE, 8'hFF);
        send_item(CMD_UNUSED, 8'h5A);
        // Shortest frame the reset settings accept, then a byte dropped behind it.
        short_frame = {8'h00, 8'hA5, 8'h5A, 8'h01, mfcr_pkg::RST_PAD_BYTE,
                       mfcr_pkg::RST_PAD_BYTE, mfcr_pkg::RST_END_MARKER};
        foreach (short_frame[i]) send_item(mfcr_pkg::CMD_RECEIVE, short_frame[i]);
        send_item(mfcr_pkg::CMD_RECEIVE, 8'hFF);
        send_item(mfcr_pkg::CMD_READ, 8'hFF);
        send_item(mfcr_pkg::CMD_RELEASE, 8'h00);
        // A marker too early to close a frame, then one landing in the last entry.
        send_item(mfcr_pkg::CMD_RECEIVE, mfcr_pkg::RST_PAD_BYTE);
        send_item(mfcr_pkg::CMD_RECEIVE, mfcr_pkg::RST_PAD_BYTE);
        send_item(mfcr_pkg::CMD_RECEIVE, mfcr_pkg::RST_END_MARKER);
        repeat (mfcr_pkg::BUFFER_DEPTH - 6) send_item(mfcr_pkg::CMD_RECEIVE, 8'h80);
        send_item(mfcr_pkg::CMD_RECEIVE, mfcr_pkg::RST_PAD_BYTE);
        send_item(mfcr_pkg::CMD_RECEIVE, mfcr_pkg::RST_PAD_BYTE);
        send_item(mfcr_pkg::CMD_RECEIVE, mfcr_pkg::RST_END_MARKER);
        send_item(mfcr_pkg::CMD_READ, 8'h00);
        send_item(mfcr_pkg::CMD_RELEASE, 8'h00);
        // The store fills with no frame and restarts.
        repeat (mfcr_pkg::BUFFER_DEPTH) send_item(mfcr_pkg::CMD_RECEIVE, 8'h11);
        send_item(mfcr_pkg::CMD_RECEIVE, 8'h00);

        random_segment(24);
        wait_drained();
        set_config(8'h00, 8'h00, 2'd0, 6'd0);
        random_segment(24);
        wait_drained();

        send_idle_pct = 65;
        recv_idle_pct = 22;
        set_config(8'hFF, 8'h00, 2'd3, 6'd35);
        random_segment(24);
        wait_drained();
        set_config(8'($urandom), 8'($urandom), 2'd1, 6'd40);
        random_segment(24);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'hA5, 8'h5A, 2'd2, 6'd1);
        hold_requests++;
        random_segment(24);
        wait_drained();
        set_config(8'($urandom), 8'($urandom), 2'($urandom), 6'd63);
        random_segment(24);
        wait_drained();

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
design/mfcr_pkg.sv
design/mfcr_in_if.sv
design/mfcr_out_if.sv
design/mfcr_ctrl.sv
design/mfcr_datapath.sv
design/marker_framed_command_receiver.sv
bench/tb_marker_framed_command_receiver.sv
